// File: src/gpm_pkg.sv
// Shared types and constants for the gyro pointer mapper.
// Holds field widths, register indexes, action codes and the control/status structs.
// No dependencies.
package gpm_pkg;

    localparam int POS_W      = 13;
    localparam int ACT_W      = 2;
    localparam int DZ_W       = 10;
    localparam int FS_W       = 17;
    localparam int HALF_W     = 12;
    localparam int ANG_W      = FS_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DOWN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UP   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 2'd3;

    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST   = 10'd10;
    localparam logic [FS_W-1:0]   FULL_SCALE_RST  = 17'd128000;
    localparam logic [HALF_W-1:0] HALF_WIDTH_RST  = 12'd960;
    localparam logic [HALF_W-1:0] HALF_HEIGHT_RST = 12'd540;

    // Which job the shared divider is doing.
    typedef enum logic [1:0] {
        SEL_BIAS_V,
        SEL_BIAS_H,
        SEL_MAP_X,
        SEL_MAP_Y
    } div_sel_t;

    typedef struct packed {
        logic     calib_add;
        logic     track_off;
        logic     capture;
        logic     accumulate;
        logic     clamp;
        logic     div_start;
        div_sel_t div_sel;
        logic     out_load;
    } gpm_cmd_t;

    typedef struct packed {
        logic calibrating;
        logic calib_last;
        logic div_done;
        logic out_free;
    } gpm_status_t;

endpackage

// File: src/gpm_channels.sv
// Valid/ready channel interfaces for gyro samples in and cursor words out.
// Depends on nothing; widths follow the field list of the block.
interface gpm_sample_if #(parameter int RATE_BITS = 16);
    logic                        valid;
    logic                        ready;
    logic signed [RATE_BITS-1:0] rate_vertical;
    logic signed [RATE_BITS-1:0] rate_horizontal;
    logic                        track_held;
    logic                        click_held;

    modport source (output valid, rate_vertical, rate_horizontal, track_held, click_held,
                    input ready);
    modport sink   (input valid, rate_vertical, rate_horizontal, track_held, click_held,
                    output ready);
endinterface

interface gpm_cursor_if;
    logic        valid;
    logic        ready;
    logic [12:0] cursor_x;
    logic [12:0] cursor_y;
    logic [1:0]  mouse_action;

    modport source (output valid, cursor_x, cursor_y, mouse_action, input ready);
    modport sink   (input valid, cursor_x, cursor_y, mouse_action, output ready);
endinterface

// File: src/gpm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Caller guarantees num < den * 2**QUO_W. No package dependency.
module gpm_div #(
    parameter int DEN_W = 17,
    parameter int QUO_W = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DEN_W+QUO_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    output logic                   busy,
    output logic                   done,
    output logic [QUO_W-1:0]       quotient
);

    localparam int NUM_W = DEN_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W);

    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[QUO_W-1]};
        fits  = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Shift the low numerator bits out as quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:QUO_W];
            quo_reg <= num[QUO_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/gpm_datapath.sv
// Datapath of the gyro pointer mapper: calibration sums, biases, angles,
// click tracking, the shared divider and the output register. Uses gpm_pkg, gpm_div.
module gpm_datapath
    import gpm_pkg::*;
#(
    parameter int CALIB_SAMPLES = 10,
    parameter int RATE_BITS     = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gpm_cmd_t                    cmd,
    output gpm_status_t                 status,
    input  logic [DZ_W-1:0]             dead_zone,
    input  logic [FS_W-1:0]             full_scale,
    input  logic [HALF_W-1:0]           half_width,
    input  logic [HALF_W-1:0]           half_height,
    input  logic signed [RATE_BITS-1:0] rate_vertical,
    input  logic signed [RATE_BITS-1:0] rate_horizontal,
    input  logic                        click_held,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [POS_W-1:0]            cursor_x,
    output logic [POS_W-1:0]            cursor_y,
    output logic [ACT_W-1:0]            mouse_action
);

    localparam int CNT_W   = $clog2(CALIB_SAMPLES + 1);
    localparam int SUM_W   = RATE_BITS + $clog2(CALIB_SAMPLES);
    localparam int D_W     = RATE_BITS + 1;
    localparam int ACC_W   = ((ANG_W > D_W) ? ANG_W : D_W) + 1;
    localparam int QUO_W   = (POS_W > RATE_BITS) ? POS_W : RATE_BITS;
    localparam int DEN_W   = FS_W;
    localparam int NUM_W   = DEN_W + QUO_W;
    localparam int AVG_DIV = CALIB_SAMPLES - 1;
    localparam int PROD_W  = HALF_W + ANG_W;

    logic [CNT_W-1:0]            calib_count_reg;
    logic signed [SUM_W-1:0]     sum_v_reg;
    logic signed [SUM_W-1:0]     sum_h_reg;
    logic signed [RATE_BITS-1:0] bias_v_reg;
    logic signed [RATE_BITS-1:0] bias_h_reg;
    logic signed [D_W-1:0]       d_v_reg;
    logic signed [D_W-1:0]       d_h_reg;
    logic                        press_reg;
    logic signed [ACC_W-1:0]     acc_v_reg;
    logic signed [ACC_W-1:0]     acc_h_reg;
    logic signed [ANG_W-1:0]     angle_v_reg;
    logic signed [ANG_W-1:0]     angle_h_reg;
    logic                        tracking_prev_reg;
    logic                        button_was_down_reg;
    logic [ACT_W-1:0]            action_code_reg;
    div_sel_t                    sel_reg;
    logic [POS_W-1:0]            pos_x_reg;
    logic [POS_W-1:0]            pos_y_reg;
    logic                        out_valid_reg;
    logic [POS_W-1:0]            cursor_x_reg;
    logic [POS_W-1:0]            cursor_y_reg;
    logic [ACT_W-1:0]            act_out_reg;

    logic signed [ACC_W-1:0] dv_ext, dh_ext, mag_v, mag_h, dz_ext, fs_ext;
    logic signed [ACC_W-1:0] acc_v_next, acc_h_next;
    logic signed [SUM_W-1:0] sum_pick;
    logic signed [SUM_W:0]   sum_ext;
    logic [SUM_W:0]          sum_mag;
    logic [NUM_W-1:0]        bias_num;
    logic signed [ANG_W-1:0] map_angle;
    logic [HALF_W-1:0]       map_half;
    logic signed [ANG_W:0]   span;
    logic [ANG_W-1:0]        span_u;
    logic [PROD_W-1:0]       map_num;
    logic                    is_bias;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_busy;
    logic                    div_done;
    logic [QUO_W-1:0]        quotient;
    logic [RATE_BITS-1:0]    q_bias;

    function automatic logic signed [ANG_W-1:0] clamp_angle(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] fs
    );
        logic signed [ACC_W-1:0] r;
        r = a;
        if (a >= fs)
            r = fs;
        else if (a < -fs)
            r = -fs;
        return r[ANG_W-1:0];
    endfunction

    // Dead zone on the bias-removed rates, then accumulate.
    always_comb
    begin
        dv_ext     = ACC_W'(d_v_reg);
        dh_ext     = ACC_W'(d_h_reg);
        mag_v      = dv_ext[ACC_W-1] ? -dv_ext : dv_ext;
        mag_h      = dh_ext[ACC_W-1] ? -dh_ext : dh_ext;
        dz_ext     = signed'(ACC_W'(dead_zone));
        fs_ext     = signed'(ACC_W'(full_scale));
        acc_v_next = (press_reg ? '0 : ACC_W'(angle_v_reg)) + ((mag_v > dz_ext) ? dv_ext : '0);
        acc_h_next = (press_reg ? '0 : ACC_W'(angle_h_reg)) + ((mag_h > dz_ext) ? dh_ext : '0);
    end

    // Divider operands: rounded average or position scaling.
    always_comb
    begin
        is_bias   = (cmd.div_sel == SEL_BIAS_V) || (cmd.div_sel == SEL_BIAS_H);
        sum_pick  = (cmd.div_sel == SEL_BIAS_V) ? sum_v_reg : sum_h_reg;
        sum_ext   = (SUM_W+1)'(sum_pick);
        sum_mag   = unsigned'(sum_ext[SUM_W] ? -sum_ext : sum_ext);
        bias_num  = NUM_W'({sum_mag, 1'b0}) + NUM_W'(AVG_DIV);
        map_angle = (cmd.div_sel == SEL_MAP_X) ? angle_h_reg : angle_v_reg;
        map_half  = (cmd.div_sel == SEL_MAP_X) ? half_width : half_height;
        span      = $signed((ANG_W+1)'(full_scale)) - (ANG_W+1)'(map_angle);
        span_u    = span[ANG_W-1:0];
        map_num   = map_half * span_u;
        div_num   = is_bias ? bias_num : NUM_W'(map_num);
        div_den   = is_bias ? DEN_W'(2 * AVG_DIV) : full_scale;
        q_bias    = quotient[RATE_BITS-1:0];
    end

    gpm_div #(
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_count_reg     <= '0;
            sum_v_reg           <= '0;
            sum_h_reg           <= '0;
            tracking_prev_reg   <= 1'b0;
            button_was_down_reg <= 1'b0;
            action_code_reg     <= ACT_NONE;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.calib_add)
            begin
                // drop the first sample
                if (calib_count_reg != '0)
                begin
                    sum_v_reg <= sum_v_reg + SUM_W'(rate_vertical);
                    sum_h_reg <= sum_h_reg + SUM_W'(rate_horizontal);
                end
                calib_count_reg <= calib_count_reg + 1'b1;
            end
            if (cmd.track_off)
                tracking_prev_reg <= 1'b0;
            if (cmd.capture)
            begin
                tracking_prev_reg <= 1'b1;
                if (click_held)
                begin
                    action_code_reg     <= ACT_DOWN;
                    button_was_down_reg <= 1'b1;
                end
                else if (button_was_down_reg)
                begin
                    action_code_reg     <= ACT_UP;
                    button_was_down_reg <= 1'b0;
                end
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            d_v_reg   <= D_W'(rate_vertical) - D_W'(bias_v_reg);
            d_h_reg   <= D_W'(rate_horizontal) - D_W'(bias_h_reg);
            press_reg <= !tracking_prev_reg;
        end
        if (cmd.accumulate)
        begin
            acc_v_reg <= acc_v_next;
            acc_h_reg <= acc_h_next;
        end
        if (cmd.clamp)
        begin
            angle_v_reg <= clamp_angle(acc_v_reg, fs_ext);
            angle_h_reg <= clamp_angle(acc_h_reg, fs_ext);
        end
        if (cmd.div_start)
            sel_reg <= cmd.div_sel;
        if (div_done)
        begin
            unique case (sel_reg)
                SEL_BIAS_V: bias_v_reg <= sum_v_reg[SUM_W-1] ? -q_bias : q_bias;
                SEL_BIAS_H: bias_h_reg <= sum_h_reg[SUM_W-1] ? -q_bias : q_bias;
                SEL_MAP_X:  pos_x_reg  <= (full_scale == '0) ? POS_W'(half_width)
                                                               : quotient[POS_W-1:0];
                SEL_MAP_Y:  pos_y_reg  <= (full_scale == '0) ? POS_W'(half_height)
                                                               : quotient[POS_W-1:0];
                default:    pos_y_reg  <= pos_y_reg;
            endcase
        end
        if (cmd.out_load)
        begin
            cursor_x_reg <= pos_x_reg;
            cursor_y_reg <= pos_y_reg;
            act_out_reg  <= action_code_reg;
        end
    end

    always_comb
    begin
        status.calibrating = calib_count_reg != CNT_W'(CALIB_SAMPLES);
        status.calib_last  = calib_count_reg == CNT_W'(CALIB_SAMPLES - 1);
        status.div_done    = div_done && !div_busy;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign cursor_x     = cursor_x_reg;
    assign cursor_y     = cursor_y_reg;
    assign mouse_action = act_out_reg;

endmodule

// File: src/gpm_ctrl.sv
// Sequencer of the gyro pointer mapper: input handshake, calibration,
// tracking steps and divider jobs. Uses gpm_pkg; drives gpm_datapath.
module gpm_ctrl
    import gpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_track,
    output logic        in_ready,
    input  gpm_status_t status,
    output gpm_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_START_BV = 4'd1;
    localparam logic [3:0] ST_WAIT_BV  = 4'd2;
    localparam logic [3:0] ST_WAIT_BH  = 4'd3;
    localparam logic [3:0] ST_ACC      = 4'd4;
    localparam logic [3:0] ST_CLAMP    = 4'd5;
    localparam logic [3:0] ST_START_X  = 4'd6;
    localparam logic [3:0] ST_WAIT_X   = 4'd7;
    localparam logic [3:0] ST_WAIT_Y   = 4'd8;
    localparam logic [3:0] ST_PUSH     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = state_reg == ST_IDLE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.calibrating)
                    begin
                        cmd.calib_add = 1'b1;
                        if (status.calib_last)
                            state_next = ST_START_BV;
                    end
                    else if (!in_track)
                    begin
                        cmd.track_off = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_ACC;
                    end
                end
            end
            ST_START_BV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_BIAS_V;
                state_next    = ST_WAIT_BV;
            end
            ST_WAIT_BV:
            begin
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = SEL_BIAS_H;
                    state_next    = ST_WAIT_BH;
                end
            end
            ST_WAIT_BH:
            begin
                if (status.div_done)
                    state_next = ST_IDLE;
            end
            ST_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_START_X;
            end
            ST_START_X:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_MAP_X;
                state_next    = ST_WAIT_X;
            end
            ST_WAIT_X:
            begin
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = SEL_MAP_Y;
                    state_next    = ST_WAIT_Y;
                end
            end
            ST_WAIT_Y:
            begin
                if (status.div_done)
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                // hold until the output register frees up
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: src/gyro_pointer_mapper.sv
// Top level of the gyro pointer mapper: configuration registers, sequencer
// and datapath. Uses gpm_pkg, gpm_channels, gpm_ctrl, gpm_datapath.
//
// Takes two-axis gyro rate words with track and click buttons and returns
// absolute cursor words. The first CALIB_SAMPLES words after reset only
// calibrate: the first is dropped, the rest are averaged per axis (rounded to
// nearest) into a bias; the last one also starts two divider passes, one per
// axis, and the block takes no further word until both are done. The divider
// takes Q = max(13, RATE_BITS) steps per pass. After that, a word with
// track_held low is taken without leaving idle and gives no result. A word
// with track_held high gives one cursor word: the block steps through
// accumulate and clamp, then two passes through the single shared restoring
// divider (one quotient bit per cycle) for x and y. A finished cursor word
// sits in an output register, so the next gyro word can be taken while the
// sink stalls; the block holds only if a second result is ready before the
// first one is taken. The rising edge of track_held clears both angles;
// each angle is clamped to +-full_scale and mapped to
// half - angle*half/full_scale. mouse_action reports 1 while click is held,
// 2 after release until the next click (0 before the first click).
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while the block is idle, as the block does not enforce it.
module gyro_pointer_mapper
    import gpm_pkg::*;
#(
    parameter int CALIB_SAMPLES = 10,
    parameter int RATE_BITS     = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gpm_sample_if.sink            sample,
    gpm_cursor_if.source          cursor,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DZ_W-1:0]   dead_zone_reg;
    logic [FS_W-1:0]   full_scale_reg;
    logic [HALF_W-1:0] half_width_reg;
    logic [HALF_W-1:0] half_height_reg;

    gpm_cmd_t    cmd;
    gpm_status_t status;
    logic        in_ready;

    // Configuration registers; every index of the port maps to a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg   <= DEAD_ZONE_RST;
            full_scale_reg  <= FULL_SCALE_RST;
            half_width_reg  <= HALF_WIDTH_RST;
            half_height_reg <= HALF_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEAD_ZONE:   dead_zone_reg   <= cfg_data[DZ_W-1:0];
                REG_FULL_SCALE:  full_scale_reg  <= cfg_data[FS_W-1:0];
                REG_HALF_WIDTH:  half_width_reg  <= cfg_data[HALF_W-1:0];
                REG_HALF_HEIGHT: half_height_reg <= cfg_data[HALF_W-1:0];
                default:         dead_zone_reg   <= dead_zone_reg;
            endcase
        end
    end

    // Sequencer: owns the input handshake and steps the datapath.
    gpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_track (sample.track_held),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: calibration, accumulation, scaling and the output register.
    gpm_datapath #(
        .CALIB_SAMPLES (CALIB_SAMPLES),
        .RATE_BITS     (RATE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .dead_zone       (dead_zone_reg),
        .full_scale      (full_scale_reg),
        .half_width      (half_width_reg),
        .half_height     (half_height_reg),
        .rate_vertical   (sample.rate_vertical),
        .rate_horizontal (sample.rate_horizontal),
        .click_held      (sample.click_held),
        .out_ready       (cursor.ready),
        .out_valid       (cursor.valid),
        .cursor_x        (cursor.cursor_x),
        .cursor_y        (cursor.cursor_y),
        .mouse_action    (cursor.mouse_action)
    );

    assign sample.ready = in_ready;

endmodule

// File: src/gpm_checker.sv
// Port-level checks for the gyro pointer mapper, attached by bind.
// Uses gpm_pkg; follows gyro_pointer_mapper.
module gpm_checker
    import gpm_pkg::*;
#(
    parameter int CALIB_SAMPLES = 10
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             in_track,
    input logic             in_click,
    input logic             out_valid,
    input logic             out_ready,
    input logic [POS_W-1:0] cursor_x,
    input logic [POS_W-1:0] cursor_y,
    input logic [ACT_W-1:0] mouse_action
);

    localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);

    logic [CNT_W-1:0] seen_reg;
    logic [1:0]       pending_reg;
    logic             last_click_reg;
    logic             in_acc;
    logic             out_acc;
    logic             tracked_acc;

    assign in_acc      = in_valid && in_ready;
    assign out_acc     = out_valid && out_ready;
    assign tracked_acc = in_acc && in_track && (seen_reg == CNT_W'(CALIB_SAMPLES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            pending_reg    <= '0;
            last_click_reg <= 1'b0;
        end
        else
        begin
            if (in_acc && (seen_reg != CNT_W'(CALIB_SAMPLES)))
                seen_reg <= seen_reg + 1'b1;
            if (tracked_acc)
                last_click_reg <= in_click;
            pending_reg <= pending_reg + {1'b0, tracked_acc} - {1'b0, out_acc};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_x) && $stable(cursor_y)
                                    && $stable(mouse_action))
        else $error("cursor word changed while stalled");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2)
        else $error("more than two tracked words outstanding");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("cursor word without a tracked gyro word");

    a_click_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pending_reg == 2'd1) |-> ((mouse_action == ACT_DOWN) == last_click_reg))
        else $error("left-down code does not follow click button");

endmodule

bind gyro_pointer_mapper gpm_checker #(
    .CALIB_SAMPLES (CALIB_SAMPLES)
) u_gpm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample.valid),
    .in_ready     (sample.ready),
    .in_track     (sample.track_held),
    .in_click     (sample.click_held),
    .out_valid    (cursor.valid),
    .out_ready    (cursor.ready),
    .cursor_x     (cursor.cursor_x),
    .cursor_y     (cursor.cursor_y),
    .mouse_action (cursor.mouse_action)
);
